/* hw/rtl/ept_pkg.sv */
package ept_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int WORK_BITS        = 30;
    localparam int ATAN_COUNT       = 24;
    localparam int CW               = 34;
    localparam int ROT_W            = 18;
    localparam int TR_W             = 32;
    localparam int ANG_W            = 16;
    localparam int IN_W             = 3 * TR_W + 3 * ANG_W;
    localparam int OUT_BITS         = 9 * ROT_W + 3 * TR_W;
    localparam int OUT_W            = ((OUT_BITS + 7) / 8) * 8;
    localparam logic signed [CW-1:0] GAIN_INIT = 34'sd652032874;

    typedef logic signed [CW-1:0] cw_t;
    typedef logic signed [ROT_W-1:0] rot_t;

    typedef struct packed {
        cw_t x;
        cw_t y;
        cw_t z;
        logic neg;
    } cval_t;

    function automatic cw_t atan_val(input int i);
        cw_t r;
        case (i)
            0: r = 34'sd536870912;
            1: r = 34'sd316933406;
            2: r = 34'sd167458907;
            3: r = 34'sd85004756;
            4: r = 34'sd42667331;
            5: r = 34'sd21354465;
            6: r = 34'sd10680862;
            7: r = 34'sd5340245;
            8: r = 34'sd2670163;
            9: r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            default: r = 34'sd81;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/ept_cordic_cell.sv */
module ept_cordic_cell
    import ept_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic      clk,
    input  logic      en,
    input  cval_t [2:0] din,
    output cval_t [2:0] dout
);

    localparam cw_t ATAN = atan_val(STEP);

    cval_t [2:0] dout_reg;
    cval_t [2:0] dout_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dout_next[k].neg = din[k].neg;
            if (!din[k].z[CW-1])
            begin
                dout_next[k].x = din[k].x - (din[k].y >>> STEP);
                dout_next[k].y = din[k].y + (din[k].x >>> STEP);
                dout_next[k].z = din[k].z - ATAN;
            end
            else
            begin
                dout_next[k].x = din[k].x + (din[k].y >>> STEP);
                dout_next[k].y = din[k].y - (din[k].x >>> STEP);
                dout_next[k].z = din[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

/* hw/rtl/ept_matrix.sv */
module ept_matrix
    import ept_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic [2:0]    en,
    input  cval_t [2:0]   cin,
    output logic [9*ROT_W-1:0] rot
);

    localparam int SH = WORK_BITS - FRAC_BITS;
    localparam int PW = 2 * (FRAC_BITS + 2);
    localparam int EW = FRAC_BITS + 2;
    typedef logic signed [EW-1:0] e_t;
    typedef logic signed [PW-1:0] p_t;
    typedef logic signed [PW:0] s_t;

    e_t [2:0] s_reg, c_reg, s_next, c_next;
    p_t a_reg, b_reg, pcc_reg, psc_reg, pcs_reg, pcr_reg;
    e_t sr2_reg, cr2_reg, sy2_reg, cy2_reg, sp2_reg;
    logic [9*ROT_W-1:0] rot_reg;

    function automatic e_t fin(input cw_t v, input logic neg);
        cw_t w;
        cw_t r;
        w = neg ? -v : v;
        r = (w + (cw_t'(1) <<< (SH - 1))) >>> SH;
        if (r > (cw_t'(1) <<< FRAC_BITS)) r = cw_t'(1) <<< FRAC_BITS;
        else if (r < -(cw_t'(1) <<< FRAC_BITS)) r = -(cw_t'(1) <<< FRAC_BITS);
        return e_t'(r);
    endfunction

    function automatic e_t rnd(input s_t v);
        s_t r;
        r = (v + (s_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return e_t'(r);
    endfunction

    function automatic logic [ROT_W-1:0] rsat(input s_t v);
        s_t r;
        r = (v + (s_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > (s_t'(1) <<< FRAC_BITS)) r = s_t'(1) <<< FRAC_BITS;
        else if (r < -(s_t'(1) <<< FRAC_BITS)) r = -(s_t'(1) <<< FRAC_BITS);
        return ROT_W'(r);
    endfunction

    function automatic logic [ROT_W-1:0] ro(input e_t v);
        return ROT_W'(v);
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s_next[k] = fin(cin[k].y, cin[k].neg);
            c_next[k] = fin(cin[k].x, cin[k].neg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s_reg <= s_next;
            c_reg <= c_next;
        end
        if (en[1])
        begin
            a_reg   <= c_reg[2] * s_reg[1];
            b_reg   <= s_reg[2] * s_reg[1];
            pcc_reg <= c_reg[2] * c_reg[1];
            psc_reg <= s_reg[2] * c_reg[1];
            pcs_reg <= c_reg[1] * s_reg[0];
            pcr_reg <= c_reg[1] * c_reg[0];
            sr2_reg <= s_reg[0];
            cr2_reg <= c_reg[0];
            sy2_reg <= s_reg[2];
            cy2_reg <= c_reg[2];
            sp2_reg <= s_reg[1];
        end
        if (en[2])
        begin
            rot_reg[0*ROT_W +: ROT_W] <= rsat(s_t'(pcc_reg));
            rot_reg[2*ROT_W +: ROT_W] <= rsat(s_t'(psc_reg));
            rot_reg[6*ROT_W +: ROT_W] <= rsat(s_t'(pcs_reg));
            rot_reg[7*ROT_W +: ROT_W] <= rsat(s_t'(pcr_reg));
            rot_reg[5*ROT_W +: ROT_W] <= ro(-sp2_reg);
            rot_reg[1*ROT_W +: ROT_W] <= rsat(s_t'(rnd(s_t'(a_reg)) * sr2_reg)
                                             - s_t'(sy2_reg * cr2_reg));
            rot_reg[8*ROT_W +: ROT_W] <= rsat(s_t'(rnd(s_t'(a_reg)) * cr2_reg)
                                             + s_t'(sy2_reg * sr2_reg));
            rot_reg[3*ROT_W +: ROT_W] <= rsat(s_t'(rnd(s_t'(b_reg)) * sr2_reg)
                                             + s_t'(cy2_reg * cr2_reg));
            rot_reg[4*ROT_W +: ROT_W] <= rsat(s_t'(rnd(s_t'(b_reg)) * cr2_reg)
                                             - s_t'(cy2_reg * sr2_reg));
        end
    end

    // Slot order: m00 m01 m10 m11 m12 m20 m21 m22 m02.
    assign rot = rot_reg;

endmodule

/* hw/rtl/euler_pose_to_transform.sv */
// Throughput: one request per cycle; the pipeline stalls only when the output is held.
// Each CORDIC stage is one cell that rotates the three angles side by side; an input
// register leads the cells, and three product and rounding stages follow them.
// Reset clears the valid bits of every stage; payload registers are not reset.
module euler_pose_to_transform
    import ept_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // trans_x, trans_y, trans_z, roll_angle, pitch_angle, yaw_angle
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23
    output logic [OUT_W-1:0] m_tdata
);

    localparam int NS = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
    localparam int NP = NS + 4;

    logic [NP-1:0] vld_reg;
    logic [NP-1:0] vld_next;
    logic [2:0]    en;
    logic          adv;
    logic [3*TR_W-1:0] tr_reg [NP];
    cval_t [2:0] chain [NS+1];
    cval_t [2:0] c0;
    cval_t [2:0] c0_reg;
    logic [9*ROT_W-1:0] rot;

    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [31:0] p;
            p = {s_tdata[3*TR_W + k*ANG_W +: ANG_W], 16'd0};
            c0[k].neg = (p[31:30] == 2'd1) || (p[31:30] == 2'd2);
            if (c0[k].neg) p = p + 32'h8000_0000;
            c0[k].x = GAIN_INIT;
            c0[k].y = '0;
            c0[k].z = CW'(signed'(p));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg <= c0;
        end
    end

    assign chain[0] = c0_reg;

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_cell
            ept_cordic_cell #(.STEP(g)) u_cell (
                .clk (clk),
                .en  (adv),
                .din (chain[g]),
                .dout(chain[g+1])
            );
        end
    endgenerate

    assign en = {3{adv}};

    ept_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .clk (clk),
        .en  (en),
        .cin (chain[NS]),
        .rot (rot)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tr_reg[0] <= s_tdata[3*TR_W-1:0];
            for (int i = 1; i < NP; i++)
            begin
                tr_reg[i] <= tr_reg[i-1];
            end
        end
    end

    assign vld_next = {vld_reg[NP-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    assign m_tvalid = vld_reg[NP-1];
    assign m_tdata = {
        {(OUT_W - OUT_BITS){1'b0}},
        tr_reg[NP-1][3*TR_W-1 -: TR_W],
        rot[7*ROT_W +: ROT_W], rot[6*ROT_W +: ROT_W], rot[5*ROT_W +: ROT_W],
        tr_reg[NP-1][2*TR_W-1 -: TR_W],
        rot[4*ROT_W +: ROT_W], rot[3*ROT_W +: ROT_W], rot[2*ROT_W +: ROT_W],
        tr_reg[NP-1][TR_W-1:0],
        rot[8*ROT_W +: ROT_W], rot[1*ROT_W +: ROT_W], rot[0*ROT_W +: ROT_W]
    };

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0]) else $error("request lost");

endmodule

/* dv/euler_pose_to_transform_test.sv */
module euler_pose_to_transform_test
    import ept_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;
    localparam int LATENCY = STEPS + 4;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [ANG_W-1:0] yaw;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] roll;
        logic signed [TR_W-1:0]  tz;
        logic signed [TR_W-1:0]  ty;
        logic signed [TR_W-1:0]  tx;
    } pose_t;

    typedef struct packed {
        logic signed [TR_W-1:0]  m23;
        rot_t                    m22;
        rot_t                    m21;
        rot_t                    m20;
        logic signed [TR_W-1:0]  m13;
        rot_t                    m12;
        rot_t                    m11;
        rot_t                    m10;
        logic signed [TR_W-1:0]  m03;
        rot_t                    m02;
        rot_t                    m01;
        rot_t                    m00;
    } matrix_t;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_half_up(longint v, int s);
        if (s <= 0)
            return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_unit(longint v);
        longint one;
        one = longint'(1) << FRAC;
        if (v > one)
            return one;
        if (v < -one)
            return -one;
        return v;
    endfunction

    function automatic longint atan_entry(int i);
        longint tab [24];
        tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10680862, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861, 10430, 5215,
                2608, 1304, 652, 326, 163, 81};
        return tab[i];
    endfunction

    function automatic void angle_sin_cos(input logic [ANG_W-1:0] ang, output longint s,
                                          output longint c);
        logic [31:0] ph;
        bit flip;
        longint x, y, z, nx, ny;
        ph = {ang, 16'h0000};
        flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
        if (flip)
            ph = ph + 32'h8000_0000;
        x = 652032874;
        y = 0;
        z = longint'(signed'(ph));
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z -= atan_entry(i);
            end
            else
            begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z += atan_entry(i);
            end
            x = nx;
            y = ny;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clamp_unit(round_half_up(x, WORK_BITS - FRAC));
        s = clamp_unit(round_half_up(y, WORK_BITS - FRAC));
    endfunction

    function automatic rot_t to_rot(longint v);
        longint t;
        t = clamp_unit(v);
        return t[ROT_W-1:0];
    endfunction

    function automatic matrix_t pose_matrix(pose_t p);
        longint sr, cr, sp, cp, sy, cy, a, b;
        matrix_t m;
        angle_sin_cos(p.roll, sr, cr);
        angle_sin_cos(p.pitch, sp, cp);
        angle_sin_cos(p.yaw, sy, cy);
        a = round_half_up(cy * sp, FRAC);
        b = round_half_up(sy * sp, FRAC);
        m.m00 = to_rot(round_half_up(cy * cp, FRAC));
        m.m01 = to_rot(round_half_up(a * sr - sy * cr, FRAC));
        m.m02 = to_rot(round_half_up(a * cr + sy * sr, FRAC));
        m.m03 = p.tx;
        m.m10 = to_rot(round_half_up(sy * cp, FRAC));
        m.m11 = to_rot(round_half_up(b * sr + cy * cr, FRAC));
        m.m12 = to_rot(round_half_up(b * cr - cy * sr, FRAC));
        m.m13 = p.ty;
        m.m20 = to_rot(-sp);
        m.m21 = to_rot(round_half_up(cp * sr, FRAC));
        m.m22 = to_rot(round_half_up(cp * cr, FRAC));
        m.m23 = p.tz;
        return m;
    endfunction

    class transform_scoreboard;
        matrix_t pending[$];
        int errors;

        function void note_pose(pose_t p);
            pending.push_back(pose_matrix(p));
        endfunction

        function void check_matrix(matrix_t got);
            matrix_t exp_m;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected matrix %h", $time, got);
                errors++;
                return;
            end
            exp_m = pending.pop_front();
            for (int f = 0; f < 12; f++)
            begin
                longint ev, av;
                case (f)
                    0: begin ev = exp_m.m00; av = got.m00; end
                    1: begin ev = exp_m.m01; av = got.m01; end
                    2: begin ev = exp_m.m02; av = got.m02; end
                    3: begin ev = exp_m.m03; av = got.m03; end
                    4: begin ev = exp_m.m10; av = got.m10; end
                    5: begin ev = exp_m.m11; av = got.m11; end
                    6: begin ev = exp_m.m12; av = got.m12; end
                    7: begin ev = exp_m.m13; av = got.m13; end
                    8: begin ev = exp_m.m20; av = got.m20; end
                    9: begin ev = exp_m.m21; av = got.m21; end
                    10: begin ev = exp_m.m22; av = got.m22; end
                    default: begin ev = exp_m.m23; av = got.m23; end
                endcase
                if (ev != av)
                begin
                    $display("%0t: entry %0d expected %0d actual %0d", $time, f, ev, av);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;

    transform_scoreboard board;
    bit calm;
    bit hold_off;
    longint cycles;

    euler_pose_to_transform i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_pose(pose_t'(s_tdata));
        if (rst_n && m_tvalid && m_tready)
            board.check_matrix(matrix_t'(m_tdata[OUT_BITS-1:0]));
    end

    task automatic send_pose(input pose_t p);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] specials [8];
        specials = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h8001,
                     16'h3FFF, 16'h4001};
        if ($urandom_range(0, 4) == 0)
            return specials[$urandom_range(0, 7)] + 16'($urandom_range(0, 2)) - 16'd1;
        return 16'($urandom);
    endfunction

    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (3 * LATENCY + 40) @(posedge clk);
                hold_off = 1'b0;
            end
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        pose_t p;
        logic [15:0] corner [6];
        int wait_cycles;
        board = new();
        calm = 1'b0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h8001};
        for (int k = 0; k < 24; k++)
        begin
            p.tx = (k % 3 == 0) ? 32'h7FFF_FFFF : (k % 3 == 1) ? 32'h8000_0000 : 32'hFFFF_FFFF;
            p.ty = (k % 2 == 0) ? 32'h0000_0000 : 32'h5555_AAAA;
            p.tz = (k % 2 == 0) ? 32'hAAAA_5555 : 32'h0001_0000;
            p.roll = corner[k % 6];
            p.pitch = corner[(k / 6 + k) % 6];
            p.yaw = corner[(k / 2) % 6];
            send_pose(p);
        end

        for (int n = 0; n < 1000; n++)
        begin
            if (n == 300)
                hold_off = 1'b1;
            if (n == 850)
                calm = 1'b1;
            p.tx = $urandom;
            p.ty = $urandom;
            p.tz = $urandom;
            p.roll = pick_angle();
            p.pitch = pick_angle();
            p.yaw = pick_angle();
            send_pose(p);
        end
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < 2 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ept_pkg.sv
hw/rtl/ept_cordic_cell.sv
hw/rtl/ept_matrix.sv
hw/rtl/euler_pose_to_transform.sv
dv/euler_pose_to_transform_test.sv
